// ----- hw/rtl/bckq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button chord key event queue package
// Shared types and constants for the key event queue core.
// ----------------------------------------------------------------------------
package bckq_pkg;

   localparam int INTERVAL_W = 10;
   localparam int TIME_W = 32;
   localparam int BUTTON_W = 5;
   localparam int LOGICAL_W = 7;
   localparam int KEY_W = 3;
   localparam int ENTRY_W = KEY_W + 1;

   localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RESET = 10'd10;

   localparam logic [2:0] LK_UP = 3'd0;
   localparam logic [2:0] LK_DOWN = 3'd1;
   localparam logic [2:0] LK_LEFT = 3'd2;
   localparam logic [2:0] LK_RIGHT = 3'd3;
   localparam logic [2:0] LK_OK = 3'd4;
   localparam logic [2:0] LK_USE = 3'd5;
   localparam logic [2:0] LK_ESCAPE = 3'd6;

   localparam logic [KEY_W-1:0] KC_UP = 3'd0;
   localparam logic [KEY_W-1:0] KC_DOWN = 3'd1;
   localparam logic [KEY_W-1:0] KC_LEFT = 3'd2;
   localparam logic [KEY_W-1:0] KC_RIGHT = 3'd3;
   localparam logic [KEY_W-1:0] KC_ENTER = 3'd4;
   localparam logic [KEY_W-1:0] KC_FIRE = 3'd5;
   localparam logic [KEY_W-1:0] KC_USE = 3'd6;
   localparam logic [KEY_W-1:0] KC_ESCAPE = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_DERIVE,
      ST_SCAN,
      ST_CHECK,
      ST_POP_RD,
      ST_POP_TAKE,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             press;
   } entry_type;

   typedef struct packed {
      logic      push;
      logic      pop_rd;
      logic      pop_take;
      entry_type wr_entry;
   } queue_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic             event_valid;
      logic [KEY_W-1:0] key_code;
      logic             key_pressed;
   } result_type;

   function automatic logic [KEY_W-1:0] key_for(input logic [2:0] idx, input logic second);
      logic [KEY_W-1:0] code;
      unique case (idx)
         LK_UP: code = KC_UP;
         LK_DOWN: code = KC_DOWN;
         LK_LEFT: code = KC_LEFT;
         LK_RIGHT: code = KC_RIGHT;
         LK_OK: code = second ? KC_FIRE : KC_ENTER;
         LK_USE: code = KC_USE;
         default: code = KC_ESCAPE;
      endcase
      return code;
   endfunction

endpackage

// ----- hw/rtl/bckq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bckq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/bckq_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event queue
// Circular buffer with fill count; pushes into a full queue are dropped.
// ----------------------------------------------------------------------------
module bckq_queue #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bckq_pkg::queue_cmd_type    cmd,
   output bckq_pkg::queue_status_type status,
   output bckq_pkg::entry_type        rd_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push_ok;
   logic [bckq_pkg::ENTRY_W-1:0] rd_data;

   assign status.empty = (cnt_ff == '0);
   assign status.full = (cnt_ff == CNT_W'(DEPTH));
   assign push_ok = cmd.push && !status.full;
   assign rd_entry = bckq_pkg::entry_type'(rd_data);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.pop_take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   bckq_ram #(
      .WIDTH(bckq_pkg::ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (push_ok),
      .wr_addr(wr_ptr_ff),
      .wr_data(cmd.wr_entry),
      .rd_en  (cmd.pop_rd),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

endmodule

// ----- hw/rtl/bckq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event sequencer
// Samples buttons, derives chord keys and pushes changed keys one per cycle.
// ----------------------------------------------------------------------------
module bckq_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bckq_pkg::TIME_W-1:0]          req_now_ms,
   input  logic [bckq_pkg::BUTTON_W-1:0]        req_buttons_n,
   input  logic [bckq_pkg::INTERVAL_W-1:0]      sample_interval,
   input  bckq_pkg::queue_status_type           q_status,
   input  bckq_pkg::entry_type                  q_rd_entry,
   output bckq_pkg::queue_cmd_type              q_cmd,
   output logic                                 res_valid,
   output bckq_pkg::result_type                 res,
   input  logic                                 res_ack
);

   bckq_pkg::state_type state_ff, state_in;

   logic [bckq_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [bckq_pkg::BUTTON_W-1:0]  buttons_ff, buttons_in;
   logic [bckq_pkg::TIME_W-1:0]    last_ff, last_in;
   logic [bckq_pkg::BUTTON_W-1:0]  held_ff, held_in;
   logic [bckq_pkg::LOGICAL_W-1:0] prev_ff, prev_in;
   logic [bckq_pkg::LOGICAL_W-1:0] logical_ff, logical_in;
   logic [bckq_pkg::LOGICAL_W-1:0] diff_ff, diff_in;
   logic [2:0]                     idx_ff, idx_in;
   logic                           second_ff, second_in;
   bckq_pkg::result_type           res_ff, res_in;

   logic [bckq_pkg::TIME_W-1:0]    elapsed;
   logic                           due;
   logic [bckq_pkg::LOGICAL_W-1:0] derived;
   logic                           ok_first;

   assign elapsed = now_ff - last_ff;
   assign due = (last_ff == '0) ||
                (elapsed >= {{(bckq_pkg::TIME_W - bckq_pkg::INTERVAL_W){1'b0}}, sample_interval});
   assign ok_first = (idx_ff == bckq_pkg::LK_OK) && !second_ff;
   assign res = res_ff;

   always_comb begin
      derived = '0;
      derived[bckq_pkg::LK_OK] = held_ff[bckq_pkg::LK_OK];
      if (held_ff[bckq_pkg::LK_LEFT] && held_ff[bckq_pkg::LK_RIGHT]) begin
         derived[bckq_pkg::LK_USE] = 1'b1;
      end else begin
         derived[bckq_pkg::LK_LEFT] = held_ff[bckq_pkg::LK_LEFT];
         derived[bckq_pkg::LK_RIGHT] = held_ff[bckq_pkg::LK_RIGHT];
      end
      if (held_ff[bckq_pkg::LK_UP] && held_ff[bckq_pkg::LK_DOWN]) begin
         derived[bckq_pkg::LK_ESCAPE] = 1'b1;
      end else begin
         derived[bckq_pkg::LK_UP] = held_ff[bckq_pkg::LK_UP];
         derived[bckq_pkg::LK_DOWN] = held_ff[bckq_pkg::LK_DOWN];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bckq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = q_status.empty ? bckq_pkg::ST_SAMPLE : bckq_pkg::ST_POP_RD;
            end
         end
         bckq_pkg::ST_SAMPLE: state_in = bckq_pkg::ST_DERIVE;
         bckq_pkg::ST_DERIVE: state_in = bckq_pkg::ST_SCAN;
         bckq_pkg::ST_SCAN: begin
            if (!(diff_ff[idx_ff] && ok_first) && idx_ff == bckq_pkg::LK_ESCAPE) begin
               state_in = bckq_pkg::ST_CHECK;
            end
         end
         bckq_pkg::ST_CHECK: begin
            state_in = q_status.empty ? bckq_pkg::ST_DELIVER : bckq_pkg::ST_POP_RD;
         end
         bckq_pkg::ST_POP_RD: state_in = bckq_pkg::ST_POP_TAKE;
         bckq_pkg::ST_POP_TAKE: state_in = bckq_pkg::ST_DELIVER;
         bckq_pkg::ST_DELIVER: begin
            if (res_ack) begin
               state_in = bckq_pkg::ST_IDLE;
            end
         end
         default: state_in = bckq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      q_cmd = '0;
      q_cmd.wr_entry.key = bckq_pkg::key_for(idx_ff, second_ff);
      q_cmd.wr_entry.press = logical_ff[idx_ff];
      now_in = now_ff;
      buttons_in = buttons_ff;
      last_in = last_ff;
      held_in = held_ff;
      prev_in = prev_ff;
      logical_in = logical_ff;
      diff_in = diff_ff;
      idx_in = idx_ff;
      second_in = second_ff;
      res_in = res_ff;
      unique case (state_ff)
         bckq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            now_in = req_now_ms;
            buttons_in = req_buttons_n;
         end
         bckq_pkg::ST_SAMPLE: begin
            if (due) begin
               held_in = ~buttons_ff;
               last_in = now_ff;
            end
         end
         bckq_pkg::ST_DERIVE: begin
            logical_in = derived;
            diff_in = derived ^ prev_ff;
            prev_in = derived;
            idx_in = '0;
            second_in = 1'b0;
         end
         bckq_pkg::ST_SCAN: begin
            q_cmd.push = diff_ff[idx_ff];
            if (diff_ff[idx_ff] && ok_first) begin
               second_in = 1'b1;
            end else begin
               second_in = 1'b0;
               idx_in = idx_ff + 1'b1;
            end
         end
         bckq_pkg::ST_CHECK: begin
            res_in = '0;
         end
         bckq_pkg::ST_POP_RD: begin
            q_cmd.pop_rd = 1'b1;
         end
         bckq_pkg::ST_POP_TAKE: begin
            q_cmd.pop_take = 1'b1;
            res_in.event_valid = 1'b1;
            res_in.key_code = q_rd_entry.key;
            res_in.key_pressed = q_rd_entry.press;
         end
         bckq_pkg::ST_DELIVER: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bckq_pkg::ST_IDLE;
         last_ff <= '0;
         held_ff <= '0;
         prev_ff <= '0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
         held_ff <= held_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      buttons_ff <= buttons_in;
      logical_ff <= logical_in;
      diff_ff <= diff_in;
      idx_ff <= idx_in;
      second_ff <= second_in;
      res_ff <= res_in;
   end

endmodule

// ----- hw/rtl/button_chord_key_event_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button chord key event queue core
// Polls return a queued key event, or resample the buttons when due, push
// changed chord keys and return the first event, or return an empty result.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_ready  now_ms, buttons_n
//  rsp      out        rsp_valid/rsp_ready  event_valid, key_code, key_pressed
//  csr      in         csr_wr_en            sample interval in ms
//
// A poll that finds the queue non-empty passes POP_RD, POP_TAKE and DELIVER;
// a sampling poll passes SAMPLE, DERIVE, SCAN and CHECK: the sequencer visits
// the seven logical keys one per cycle, OK twice when it changes, then reads
// the queue RAM if it holds an item. req_ready is high only while idle, and a
// stalled result holds in the output register while the next item is taken.
// Synchronous reset clears the queue and key history.
// ----------------------------------------------------------------------------
module button_chord_key_event_queue_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bckq_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [bckq_pkg::BUTTON_W-1:0]      req_buttons_n,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_event_valid,
   output logic [bckq_pkg::KEY_W-1:0]         rsp_key_code,
   output logic                               rsp_key_pressed,
   input  logic                               csr_wr_en,
   input  logic [bckq_pkg::INTERVAL_W-1:0]    csr_wr_data
);

   logic [bckq_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bckq_pkg::result_type            rsp_ff, rsp_in;

   bckq_pkg::queue_cmd_type    q_cmd;
   bckq_pkg::queue_status_type q_status;
   bckq_pkg::entry_type        q_rd_entry;
   logic                       res_valid;
   logic                       res_ack;
   bckq_pkg::result_type       res;

   assign res_ack = res_valid && (!rsp_valid_ff || rsp_ready);
   assign interval_in = csr_wr_en ? csr_wr_data : interval_ff;
   assign rsp_in = res_ack ? res : rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= bckq_pkg::SAMPLE_INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         interval_ff <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_valid = rsp_ff.event_valid;
   assign rsp_key_code = rsp_ff.key_code;
   assign rsp_key_pressed = rsp_ff.key_pressed;

   bckq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_now_ms     (req_now_ms),
      .req_buttons_n  (req_buttons_n),
      .sample_interval(interval_ff),
      .q_status       (q_status),
      .q_rd_entry     (q_rd_entry),
      .q_cmd          (q_cmd),
      .res_valid      (res_valid),
      .res            (res),
      .res_ack        (res_ack)
   );

   bckq_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (q_cmd),
      .status  (q_status),
      .rd_entry(q_rd_entry)
   );

`ifndef ASSERT_OFF
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(q_cmd.push && (q_cmd.pop_rd || q_cmd.pop_take)))
      else $error("Queue push and pop in the same cycle.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Ready stayed high after an item was accepted.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_cmd.pop_take |-> (!q_status.empty && $past(q_cmd.pop_rd)))
      else $error("Queue pop without a pending read of a filled entry.");
`endif

endmodule

// ----- verif/key_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event queue checker
// Watches the poll, result and interval ports of the key event queue core.
// It keeps its own copy of the event queue, the key history and the sample
// timer, predicts one result for every accepted poll and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module key_event_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [bckq_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [bckq_pkg::BUTTON_W-1:0]      req_buttons_n,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_event_valid,
   input  logic [bckq_pkg::KEY_W-1:0]         rsp_key_code,
   input  logic                               rsp_key_pressed,
   input  logic                               csr_wr_en,
   input  logic [bckq_pkg::INTERVAL_W-1:0]    csr_wr_data,
   output int                                 fail_count,
   output int                                 pending
);

   import bckq_pkg::*;

   localparam int PRINT_CAP = 40;

   logic [INTERVAL_W-1:0] interval_ms;
   logic [KEY_W-1:0]      event_code [QUEUE_DEPTH];
   logic                  event_press [QUEUE_DEPTH];
   int                    rd_ptr;
   int                    wr_ptr;
   int                    fill;
   logic [LOGICAL_W-1:0]  prev_keys;
   logic [TIME_W-1:0]     last_sample_ms;
   logic [BUTTON_W-1:0]   held_buttons;

   result_type expected_events[$];
   int mismatches = 0;
   int outstanding = 0;

   assign fail_count = mismatches;
   assign pending = outstanding;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_CAP) begin
         $display("%0t ns: key event %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   task automatic queue_event(input logic [KEY_W-1:0] code, input logic press);
      if (fill < QUEUE_DEPTH) begin
         event_code[wr_ptr] = code;
         event_press[wr_ptr] = press;
         wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
         fill++;
      end
   endtask

   task automatic take_event(output result_type r);
      r = '0;
      if (fill != 0) begin
         r.event_valid = 1'b1;
         r.key_code = event_code[rd_ptr];
         r.key_pressed = event_press[rd_ptr];
         rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
         fill--;
      end
   endtask

   task automatic predict_poll(input logic [TIME_W-1:0] now, input logic [BUTTON_W-1:0] btn_n,
                               output result_type r);
      logic [TIME_W-1:0]    elapsed;
      logic [LOGICAL_W-1:0] keys;
      logic [LOGICAL_W-1:0] changed;
      if (fill != 0) begin
         take_event(r);
      end else begin
         elapsed = now - last_sample_ms;
         if (last_sample_ms == '0 || elapsed >= TIME_W'(interval_ms)) begin
            held_buttons = ~btn_n;
            last_sample_ms = now;
         end
         // A pressed pair becomes its chord key and hides both of its members.
         keys = '0;
         keys[LK_OK] = held_buttons[LK_OK];
         if (held_buttons[LK_LEFT] && held_buttons[LK_RIGHT]) begin
            keys[LK_USE] = 1'b1;
         end else begin
            keys[LK_LEFT] = held_buttons[LK_LEFT];
            keys[LK_RIGHT] = held_buttons[LK_RIGHT];
         end
         if (held_buttons[LK_UP] && held_buttons[LK_DOWN]) begin
            keys[LK_ESCAPE] = 1'b1;
         end else begin
            keys[LK_UP] = held_buttons[LK_UP];
            keys[LK_DOWN] = held_buttons[LK_DOWN];
         end
         changed = keys ^ prev_keys;
         for (int i = 0; i < LOGICAL_W; i++) begin
            if (changed[i]) begin
               case (i)
                  LK_UP: queue_event(KC_UP, keys[i]);
                  LK_DOWN: queue_event(KC_DOWN, keys[i]);
                  LK_LEFT: queue_event(KC_LEFT, keys[i]);
                  LK_RIGHT: queue_event(KC_RIGHT, keys[i]);
                  LK_OK: begin
                     queue_event(KC_ENTER, keys[i]);
                     queue_event(KC_FIRE, keys[i]);
                  end
                  LK_USE: queue_event(KC_USE, keys[i]);
                  default: queue_event(KC_ESCAPE, keys[i]);
               endcase
            end
         end
         prev_keys = keys;
         take_event(r);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         interval_ms = SAMPLE_INTERVAL_RESET;
         rd_ptr = 0;
         wr_ptr = 0;
         fill = 0;
         prev_keys = '0;
         last_sample_ms = '0;
         held_buttons = '0;
         expected_events.delete();
      end else begin
         if (csr_wr_en) begin
            interval_ms = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            predict_poll(req_now_ms, req_buttons_n, want);
            expected_events.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got.event_valid = rsp_event_valid;
            got.key_code = rsp_key_code;
            got.key_pressed = rsp_key_pressed;
            if (expected_events.size() == 0) begin
               report_mismatch("result with no poll waiting", int'(got), 0);
            end else begin
               want = expected_events.pop_front();
               if (got.event_valid !== want.event_valid) begin
                  report_mismatch("event_valid", got.event_valid, want.event_valid);
               end
               if (got.key_code !== want.key_code) begin
                  report_mismatch("key_code", got.key_code, want.key_code);
               end
               if (got.key_pressed !== want.key_pressed) begin
                  report_mismatch("key_pressed", got.key_pressed, want.key_pressed);
               end
            end
         end
      end
      outstanding <= expected_events.size();
   end

endmodule

// ----- verif/tb_button_chord_key_event_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event queue core testbench
// Drives button polls through a directed opening and several sample interval
// settings with random times and chord-heavy button patterns, idles both
// sides in short bursts, and once holds off the result side for a long
// stretch. The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_button_chord_key_event_queue_core;

   import bckq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int N_DIRECTED = 23;
   localparam int N_PHASES = 6;
   localparam int PHASE_ITEMS = 330;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 500000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic [BUTTON_W-1:0]   req_buttons_n = '1;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_event_valid;
   logic [KEY_W-1:0]      rsp_key_code;
   logic                  rsp_key_pressed;
   logic                  csr_wr_en = 1'b0;
   logic [INTERVAL_W-1:0] csr_wr_data = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int cur_interval = SAMPLE_INTERVAL_RESET;
   int tx_calm = 0;
   bit no_idle = 1'b0;
   bit long_hold = 1'b0;

   logic [TIME_W-1:0] dir_time [N_DIRECTED] = '{
      32'd0, 32'd0, 32'd3, 32'd4, 32'd6, 32'd13, 32'd14, 32'd30, 32'd31, 32'd32,
      32'd50, 32'd51, 32'd52, 32'd53, 32'hFFFF_FFF0, 32'd5, 32'd6, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'd9, 32'd10, 32'd11, 32'h5555_AAAA
   };
   logic [BUTTON_W-1:0] dir_buttons [N_DIRECTED] = '{
      5'h1F, 5'h1E, 5'h1C, 5'h1C, 5'h1F, 5'h13, 5'h13, 5'h00, 5'h00, 5'h00,
      5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1B, 5'h17, 5'h17, 5'h1D,
      5'h0F, 5'h0F, 5'h0F, 5'h0F, 5'h1A
   };
   logic [BUTTON_W-1:0] chord_patterns [12] = '{
      5'h1F, 5'h1E, 5'h1D, 5'h1C, 5'h1B, 5'h17, 5'h13, 5'h0F,
      5'h00, 5'h10, 5'h03, 5'h0C
   };
   int phase_interval [N_PHASES] = '{0, 1, 1023, 1000, -1, 10};

   button_chord_key_event_queue_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_now_ms(req_now_ms),
      .req_buttons_n(req_buttons_n),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_valid(rsp_event_valid),
      .rsp_key_code(rsp_key_code),
      .rsp_key_pressed(rsp_key_pressed),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   key_event_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_now_ms(req_now_ms),
      .req_buttons_n(req_buttons_n),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_valid(rsp_event_valid),
      .rsp_key_code(rsp_key_code),
      .rsp_key_pressed(rsp_key_pressed),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("button_chord_key_event_queue_core: mismatch");
         $finish;
      end
   end

   task automatic send_poll(input logic [TIME_W-1:0] now, input logic [BUTTON_W-1:0] btn_n);
      int gap;
      gap = 0;
      if (tx_calm > 0) begin
         tx_calm--;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
      end else if ($urandom_range(0, 29) == 0) begin
         tx_calm = $urandom_range(10, 40);
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_now_ms <= now;
      req_buttons_n <= btn_n;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // The interval changes only once every poll has been answered.
   task automatic write_interval(input logic [INTERVAL_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_interval = value;
   endtask

   function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] now);
      int step;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         return '0;
      end else if (pick < 6) begin
         return $urandom;
      end
      case ($urandom_range(0, 7))
         0, 1: step = $urandom_range(0, cur_interval);
         2: step = (cur_interval > 0) ? cur_interval - 1 : 0;
         3: step = cur_interval;
         4: step = cur_interval + 1;
         5: step = $urandom_range(0, 200000);
         default: step = $urandom_range(cur_interval, 3 * cur_interval + 3);
      endcase
      return now + TIME_W'(step);
   endfunction

   function automatic logic [BUTTON_W-1:0] next_buttons();
      if ($urandom_range(0, 9) < 3) begin
         return BUTTON_W'($urandom_range(0, 31));
      end
      return chord_patterns[$urandom_range(0, 11)];
   endfunction

   initial begin
      int hold_left;
      int burst_left;
      int calm_left;
      hold_left = 0;
      burst_left = 0;
      calm_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle || calm_left > 0) begin
            if (calm_left > 0) begin
               calm_left--;
            end
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 19) == 0) begin
               calm_left = $urandom_range(10, 40);
            end
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [TIME_W-1:0] now;
      int value;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_poll(dir_time[i], dir_buttons[i]);
      end

      now = 32'd100;
      for (int p = 0; p < N_PHASES; p++) begin
         value = (phase_interval[p] < 0) ? $urandom_range(1, 1000) : phase_interval[p];
         write_interval(INTERVAL_W'(value));
         if (p == N_PHASES - 1) begin
            no_idle = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 40) begin
               long_hold = 1'b1;
            end
            now = next_time(now);
            send_poll(now, next_buttons());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("button_chord_key_event_queue_core: match");
      end else begin
         $display("button_chord_key_event_queue_core: mismatch");
      end
      $finish;
   end

endmodule
